// ===== hdl/bbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pkg
// shared types and constants of the bilinear bayer demosaic unit
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ROW_LIMIT  = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
  localparam int COORD_BITS = 10;
  localparam int SIZE_BITS  = 11;
  localparam int CFG_IDX_BITS = 1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FRAME_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_FRAME_HEIGHT = 1'b1;

  localparam size_t WIDTH_RESET  = 11'd160;
  localparam size_t HEIGHT_RESET = 11'd120;

endpackage

// ===== hdl/bbd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_in_if / bbd_out_if
// valid/ready channels for raw samples and demosaiced pixels
// ----------------------------------------------------------------------------
interface bbd_in_if
  import bbd_pkg::*;
  ();
  logic   valid;
  logic   ready;
  pixel_t raw_pixel;
  logic   frame_start;

  modport source (output valid, raw_pixel, frame_start, input ready);
  modport sink (input valid, raw_pixel, frame_start, output ready);
endinterface

interface bbd_out_if
  import bbd_pkg::*;
  ();
  logic   valid;
  logic   ready;
  pixel_t red;
  pixel_t green;
  pixel_t blue;
  coord_t out_column;
  coord_t out_row;
  logic   last_of_run;
  logic   end_of_frame;

  modport source (output valid, red, green, blue, out_column, out_row, last_of_run,
                  end_of_frame, input ready);
  modport sink (input valid, red, green, blue, out_column, out_row, last_of_run,
                end_of_frame, output ready);
endinterface

// ===== hdl/bayer_bilinear_demosaic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit
// bilinear demosaic of an rggb bayer stream, one raw sample per request
// ----------------------------------------------------------------------------
// Raw samples come in raster order, one per cycle. Each output site is sent
// one row and one column behind the input: a sample gives the pixel to its
// upper left, plus the pixels of the last column and last row when it lies
// there, so a request yields 0, 1, 2 or 4 pixels. The output register sends
// one pixel per cycle while the output is not stalled, so a sample is taken
// every cycle except that samples of the last column (below the top row) and
// of the last row (right of the first column) hold the input while their
// extra pixels are sent, longest at the bottom-right corner. A request passes
// stage b and stage c before its first pixel reaches the output register.
// Both stored rows sit in one 1024 x 16 memory (upper row, middle row) read
// at the sample's column when the request is taken and written back as the
// sample leaves the read stage; a sample at the same column as the one just
// written takes its data from a forwarding register. The memory needs no
// clearing: entries read before they were written only feed sites outside the
// frame. frame_width and frame_height are clamped to 2..1024 and must be
// written only while idle.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_unit
  import bbd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  bbd_in_if.sink         in_chan,
  bbd_out_if.source      out_chan,
  input  logic           cfg_we,
  input  cfg_idx_t       cfg_index,
  input  size_t          cfg_wdata
);

  typedef enum logic [1:0] {COL_RED, COL_GREEN, COL_BLUE} colour_t;

  function automatic colour_t site_colour(input logic col_odd, input logic row_odd);
    colour_t c;
    if (row_odd) c = col_odd ? COL_BLUE : COL_GREEN;
    else         c = col_odd ? COL_GREEN : COL_RED;
    return c;
  endfunction

  // ---- configuration registers
  size_t frame_width_r, frame_height_r;
  size_t w_use, h_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp to the supported frame size
  always_comb begin
    w_use = frame_width_r;
    if (frame_width_r < 11'd2) w_use = 11'd2;
    else if (frame_width_r > SIZE_BITS'(MAX_WIDTH)) w_use = SIZE_BITS'(MAX_WIDTH);
    h_use = frame_height_r;
    if (frame_height_r < 11'd2) h_use = 11'd2;
    else if (frame_height_r > SIZE_BITS'(ROW_LIMIT)) h_use = SIZE_BITS'(ROW_LIMIT);
  end

  // ---- handshake control
  logic       in_acc;
  logic       b_valid_r;
  logic       b_adv;
  logic [3:0] c_mask_r;
  logic       c_free;
  logic       emit;
  logic       emit_last;
  logic       out_valid_r;

  assign emit   = (c_mask_r != 4'd0) && (!out_valid_r || out_chan.ready);
  assign c_free = (c_mask_r == 4'd0) || (emit && emit_last);
  assign b_adv  = b_valid_r && c_free;
  assign in_chan.ready = !b_valid_r || b_adv;
  assign in_acc = in_chan.valid && in_chan.ready;

  // ---- stage a: position counters, memory read
  coord_t col_r, row_r;
  size_t  c0, r0, c_inc, r_inc;
  coord_t x_a, y_a;
  coord_t col_nxt, row_nxt;

  always_comb begin
    c0 = in_chan.frame_start ? '0 : {1'b0, col_r};
    r0 = in_chan.frame_start ? '0 : {1'b0, row_r};
    // position left past the frame after a size change
    if (c0 >= w_use) begin
      c0 = '0;
      r0 = r0 + 11'd1;
    end
    if (r0 >= h_use) r0 = '0;
    x_a = c0[COORD_BITS-1:0];
    y_a = r0[COORD_BITS-1:0];
    c_inc = {1'b0, x_a} + 11'd1;
    r_inc = {1'b0, y_a} + 11'd1;
    col_nxt = c_inc[COORD_BITS-1:0];
    row_nxt = y_a;
    if (c_inc >= w_use) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_use) ? '0 : r_inc[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line memory: [15:8] upper row, [7:0] middle row
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] mem_q_r;
  logic [2*PIXEL_BITS-1:0] fwd_data_r;
  logic                    fwd_hit_r;
  logic [2*PIXEL_BITS-1:0] wr_data;
  logic [2*PIXEL_BITS-1:0] rd_data;
  pixel_t                  pix_b_r;
  coord_t                  x_b_r, y_b_r;

  assign rd_data = fwd_hit_r ? fwd_data_r : mem_q_r;
  // upper takes the old middle, middle takes the new sample
  assign wr_data = {rd_data[PIXEL_BITS-1:0], pix_b_r};

  always_ff @(posedge clk) begin
    if (b_adv) line_mem[x_b_r[ADDR_BITS-1:0]] <= wr_data;
    if (in_acc) mem_q_r <= line_mem[x_a[ADDR_BITS-1:0]];
  end

  // ---- stage b: read data arrives, forwarding for a same-column write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_acc) begin
      b_valid_r <= 1'b1;
    end else if (b_adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_b_r    <= in_chan.raw_pixel;
      x_b_r      <= x_a;
      y_b_r      <= y_a;
      fwd_hit_r  <= b_adv && (x_b_r == x_a);
      fwd_data_r <= wr_data;
    end
  end

  // 3x3 window, [row][col], col 2 newest
  pixel_t window_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          window_r[r][c] <= '0;
    end else if (b_adv) begin
      for (int r = 0; r < 3; r++) begin
        window_r[r][0] <= window_r[r][1];
        window_r[r][1] <= window_r[r][2];
      end
      window_r[0][2] <= rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
      window_r[1][2] <= rd_data[PIXEL_BITS-1:0];
      window_r[2][2] <= pix_b_r;
    end
  end

  // ---- stage c: one pixel per cycle from the pending mask while the output is not stalled
  // mask bit {ci,ri}: ci column offset (0 = x-1, 1 = x), ri likewise for rows
  coord_t     x_c_r, y_c_r;
  logic [3:0] mask_b;
  logic       has_left_b, has_up_b, last_col_b, last_row_b;

  always_comb begin
    has_left_b = (x_b_r != '0);
    has_up_b   = (y_b_r != '0);
    last_col_b = ({1'b0, x_b_r} == w_use - 11'd1);
    last_row_b = ({1'b0, y_b_r} == h_use - 11'd1);
    mask_b[0]  = has_left_b && has_up_b;
    mask_b[1]  = has_left_b && last_row_b;
    mask_b[2]  = last_col_b && has_up_b;
    mask_b[3]  = last_col_b && last_row_b;
  end

  logic [1:0] sel;
  logic [3:0] mask_rest;

  always_comb begin
    sel = 2'd3;
    if (c_mask_r[0])      sel = 2'd0;
    else if (c_mask_r[1]) sel = 2'd1;
    else if (c_mask_r[2]) sel = 2'd2;
    mask_rest = c_mask_r & ~(4'd1 << sel);
    emit_last = (mask_rest == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_mask_r <= '0;
    end else if (b_adv) begin
      c_mask_r <= mask_b;
    end else if (emit) begin
      c_mask_r <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      x_c_r <= x_b_r;
      y_c_r <= y_b_r;
    end
  end

  // site interpolation
  coord_t     px, py;
  logic [1:0] cc, cr;
  logic       ok_l, ok_r, ok_u, ok_d;
  logic [9:0] sum [3];
  logic [2:0] cnt [3];
  pixel_t     mean [3];
  pixel_t     own_pix;
  colour_t    own;
  logic       eof;

  always_comb begin
    logic [1:0] wr, wc;
    logic       in_frame;
    colour_t    k;
    logic [19:0] prod;
    px = sel[1] ? x_c_r : x_c_r - 10'd1;
    py = sel[0] ? y_c_r : y_c_r - 10'd1;
    cc = sel[1] ? 2'd2 : 2'd1;
    cr = sel[0] ? 2'd2 : 2'd1;
    ok_l = (px != '0);
    ok_r = ({1'b0, px} != w_use - 11'd1);
    ok_u = (py != '0);
    ok_d = ({1'b0, py} != h_use - 11'd1);
    own  = site_colour(px[0], py[0]);
    own_pix = window_r[cr][cc];
    for (int c = 0; c < 3; c++) begin
      sum[c] = '0;
      cnt[c] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wr = 2'(cr + 2'(i) - 2'd1);
        wc = 2'(cc + 2'(j) - 2'd1);
        in_frame = !(i == 1 && j == 1);
        if (i == 0 && !ok_u) in_frame = 1'b0;
        if (i == 2 && !ok_d) in_frame = 1'b0;
        if (j == 0 && !ok_l) in_frame = 1'b0;
        if (j == 2 && !ok_r) in_frame = 1'b0;
        k = site_colour(px[0] ^ (j != 1), py[0] ^ (i != 1));
        if (in_frame && wr != 2'd3 && wc != 2'd3) begin
          sum[k] = sum[k] + 10'(window_r[wr][wc]);
          cnt[k] = cnt[k] + 3'd1;
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      // divide by three as multiply by 683 / 2048, exact below 768
      prod = 20'(sum[c]) * 20'd683;
      case (cnt[c])
        3'd1:    mean[c] = sum[c][PIXEL_BITS-1:0];
        3'd2:    mean[c] = sum[c][PIXEL_BITS:1];
        3'd3:    mean[c] = prod[11 +: PIXEL_BITS];
        3'd4:    mean[c] = sum[c][PIXEL_BITS+1:2];
        default: mean[c] = '0;
      endcase
    end
    eof = !ok_r && !ok_d;
  end

  // ---- output register
  pixel_t red_r, green_r, blue_r;
  coord_t ocol_r, orow_r;
  logic   last_r, eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      red_r   <= (own == COL_RED)   ? own_pix : mean[COL_RED];
      green_r <= (own == COL_GREEN) ? own_pix : mean[COL_GREEN];
      blue_r  <= (own == COL_BLUE)  ? own_pix : mean[COL_BLUE];
      ocol_r  <= px;
      orow_r  <= py;
      last_r  <= emit_last;
      eof_r   <= eof;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.red          = red_r;
  assign out_chan.green        = green_r;
  assign out_chan.blue         = blue_r;
  assign out_chan.out_column   = ocol_r;
  assign out_chan.out_row      = orow_r;
  assign out_chan.last_of_run  = last_r;
  assign out_chan.end_of_frame = eof_r;

endmodule

// ===== hdl/bbd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_checker
// port-level checks of the demosaic unit
// ----------------------------------------------------------------------------
module bbd_checker
  import bbd_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input pixel_t out_red,
  input coord_t out_column,
  input coord_t out_row,
  input logic   out_last,
  input logic   out_eof
);

  // bottom-right site closes the run of its request
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_eof |-> out_last)
    else $error("end_of_frame without last_of_run");

  // input back-pressure only while pixels are still being sent
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid)
    else $error("input stalled with nothing to send");

  // reset empties the output register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column) && $stable(out_row)
      && $stable(out_red))
    else $error("stalled result changed");

endmodule

bind bayer_bilinear_demosaic_unit bbd_checker u_bbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_red    (out_chan.red),
  .out_column (out_chan.out_column),
  .out_row    (out_chan.out_row),
  .out_last   (out_chan.last_of_run),
  .out_eof    (out_chan.end_of_frame)
);
